[rtl/csmv_pkg.sv]
// Shared constants, command codes and queue entry types for the sparse matrix-vector block.
package csmv_pkg;

  localparam int VECTOR_DEPTH = 4096;
  localparam int VALUE_WIDTH  = 32;
  localparam int IDX_W        = $clog2(VECTOR_DEPTH);
  localparam int ENTRY_W      = 12;
  localparam int IN_W         = 32;
  localparam int CMD_W        = 2;
  localparam int PROD_W       = 2 * VALUE_WIDTH;
  localparam int ACC_W        = 64;
  localparam int ROW_W        = 16;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);
  localparam int OUT_DEPTH    = 2;
  localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_NONZERO = 2'd1,
    CMD_EMPTY   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic                          empty_row;
    logic                          last_in_row;
    logic                          last_row;
    logic signed [VALUE_WIDTH-1:0] mat_re;
    logic signed [VALUE_WIDTH-1:0] mat_im;
    logic signed [VALUE_WIDTH-1:0] vec_re;
    logic signed [VALUE_WIDTH-1:0] vec_im;
  } work_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum_re;
    logic signed [ACC_W-1:0] sum_im;
    logic [ROW_W-1:0]        row;
    logic                    sat;
  } result_t;

endpackage

[rtl/csmv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module csmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/csmv_front.sv]
// Front end: accepts requests, writes the vector store and fetches operands for nonzero and empty-row requests.
module csmv_front
  import csmv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [ENTRY_W-1:0]    entry_index,
  input  logic signed [IN_W-1:0] value_real,
  input  logic signed [IN_W-1:0] value_imag,
  input  logic                  last_in_row,
  input  logic                  last_row,
  output logic                  q_push,
  output work_t                 q_entry,
  input  logic                  q_full
);

  logic                          accept;
  logic                          is_load;
  logic                          is_work;
  logic [IDX_W-1:0]              idx;
  logic signed [VALUE_WIDTH-1:0] a_re;
  logic signed [VALUE_WIDTH-1:0] a_im;
  logic [2*VALUE_WIDTH-1:0]      vec_rdata;
  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic                          s1_empty_r;
  logic                          s1_last_in_row_r;
  logic                          s1_last_row_r;
  logic signed [VALUE_WIDTH-1:0] s1_re_r;
  logic signed [VALUE_WIDTH-1:0] s1_im_r;

  assign full   = s1_valid_r & q_full;
  assign accept = push & ~full;
  assign idx    = IDX_W'(entry_index);
  assign a_re   = $signed(value_real[VALUE_WIDTH-1:0]);
  assign a_im   = $signed(value_imag[VALUE_WIDTH-1:0]);

  always_comb begin
    is_load = 1'b0;
    is_work = 1'b0;
    unique case (cmd_t'(cmd))
      CMD_LOAD:    is_load = 1'b1;
      CMD_NONZERO: is_work = 1'b1;
      CMD_EMPTY:   is_work = 1'b1;
      default: begin
        is_load = 1'b0;
        is_work = 1'b0;
      end
    endcase
  end

  csmv_ram #(
    .WIDTH(2 * VALUE_WIDTH),
    .DEPTH(VECTOR_DEPTH)
  ) u_vec_ram (
    .clk  (clk),
    .we   (accept & is_load),
    .waddr(idx),
    .wdata({a_re, a_im}),
    .re   (accept & is_work),
    .raddr(idx),
    .rdata(vec_rdata)
  );

  assign q_push = s1_valid_r & ~q_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (q_push || !s1_valid_r) begin
      s1_valid_nxt = accept & is_work;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_work) begin
      s1_empty_r       <= (cmd_t'(cmd) == CMD_EMPTY);
      s1_last_in_row_r <= last_in_row;
      s1_last_row_r    <= last_row;
      s1_re_r          <= a_re;
      s1_im_r          <= a_im;
    end
  end

  always_comb begin
    q_entry.empty_row   = s1_empty_r;
    q_entry.last_in_row = s1_last_in_row_r;
    q_entry.last_row    = s1_last_row_r;
    q_entry.mat_re      = s1_re_r;
    q_entry.mat_im      = s1_im_r;
    q_entry.vec_re      = $signed(vec_rdata[2*VALUE_WIDTH-1:VALUE_WIDTH]);
    q_entry.vec_im      = $signed(vec_rdata[VALUE_WIDTH-1:0]);
  end

endmodule

[rtl/csmv_queue.sv]
// Short work queue between the front end and the arithmetic back end.
module csmv_queue
  import csmv_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t wr_entry,
  output logic  full,
  input  logic  pop,
  output work_t rd_entry,
  output logic  valid
);

  work_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign valid    = (cnt_r != '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & valid;
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

[rtl/csmv_back.sv]
// Back end: complex multiply, saturating row accumulation and result buffer.
module csmv_back
  import csmv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  work_t                   q_entry,
  output logic                    q_pop,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [ACC_W-1:0] sum_real,
  output logic signed [ACC_W-1:0] sum_imag,
  output logic [ROW_W-1:0]        row_number,
  output logic                    saturated
);

  logic                     advance;
  logic                     b1_valid_r;
  logic                     b1_empty_r;
  logic                     b1_end_r;
  logic                     b1_last_row_r;
  logic signed [PROD_W-1:0] p_rr_r;
  logic signed [PROD_W-1:0] p_ii_r;
  logic signed [PROD_W-1:0] p_ri_r;
  logic signed [PROD_W-1:0] p_ir_r;
  logic                     b2_valid_r;
  logic                     b2_empty_r;
  logic                     b2_end_r;
  logic                     b2_last_row_r;
  logic signed [ACC_W-1:0]  term_re_r;
  logic signed [ACC_W-1:0]  term_im_r;
  logic signed [ACC_W-1:0]  acc_re_r;
  logic signed [ACC_W-1:0]  acc_im_r;
  logic                     row_sat_r;
  logic [ROW_W-1:0]         row_cnt_r;
  logic signed [ACC_W-1:0]  sum_re;
  logic signed [ACC_W-1:0]  sum_im;
  logic                     ovf_re;
  logic                     ovf_im;
  logic signed [ACC_W-1:0]  acc_re_nxt;
  logic signed [ACC_W-1:0]  acc_im_nxt;
  logic                     row_sat_nxt;
  logic                     act;
  logic                     emit;
  result_t                  res;
  result_t                  out_mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]     out_wr_ptr_r;
  logic [OUT_PTR_W-1:0]     out_rd_ptr_r;
  logic [OUT_CNT_W-1:0]     out_cnt_r;
  logic                     out_pop;

  assign advance = (out_cnt_r != OUT_CNT_W'(OUT_DEPTH));
  assign q_pop   = advance & q_valid;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else if (advance) begin
      b1_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_empty_r    <= q_entry.empty_row;
      b1_end_r      <= q_entry.last_in_row;
      b1_last_row_r <= q_entry.last_row;
      p_rr_r        <= q_entry.mat_re * q_entry.vec_re;
      p_ii_r        <= q_entry.mat_im * q_entry.vec_im;
      p_ri_r        <= q_entry.mat_re * q_entry.vec_im;
      p_ir_r        <= q_entry.mat_im * q_entry.vec_re;
    end
  end

  // term stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
    end else if (advance) begin
      b2_valid_r <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && b1_valid_r) begin
      b2_empty_r    <= b1_empty_r;
      b2_end_r      <= b1_end_r;
      b2_last_row_r <= b1_last_row_r;
      term_re_r     <= ACC_W'(p_rr_r) - ACC_W'(p_ii_r);
      term_im_r     <= ACC_W'(p_ri_r) + ACC_W'(p_ir_r);
    end
  end

  // saturating accumulate
  assign sum_re = acc_re_r + term_re_r;
  assign sum_im = acc_im_r + term_im_r;
  assign ovf_re = (acc_re_r[ACC_W-1] == term_re_r[ACC_W-1]) &&
                  (sum_re[ACC_W-1] != acc_re_r[ACC_W-1]);
  assign ovf_im = (acc_im_r[ACC_W-1] == term_im_r[ACC_W-1]) &&
                  (sum_im[ACC_W-1] != acc_im_r[ACC_W-1]);

  always_comb begin
    acc_re_nxt  = ovf_re ? (term_re_r[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum_re;
    acc_im_nxt  = ovf_im ? (term_im_r[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum_im;
    row_sat_nxt = row_sat_r | ovf_re | ovf_im;
  end

  assign act  = advance & b2_valid_r;
  assign emit = act & (b2_empty_r | b2_end_r);

  always_comb begin
    res.row = row_cnt_r;
    if (b2_empty_r) begin
      res.sum_re = '0;
      res.sum_im = '0;
      res.sat    = 1'b0;
    end else begin
      res.sum_re = acc_re_nxt;
      res.sum_im = acc_im_nxt;
      res.sat    = row_sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r  <= '0;
      acc_im_r  <= '0;
      row_sat_r <= 1'b0;
      row_cnt_r <= '0;
    end else if (emit) begin
      acc_re_r  <= '0;
      acc_im_r  <= '0;
      row_sat_r <= 1'b0;
      row_cnt_r <= b2_last_row_r ? '0 : row_cnt_r + 1'b1;
    end else if (act) begin
      acc_re_r  <= acc_re_nxt;
      acc_im_r  <= acc_im_nxt;
      row_sat_r <= row_sat_nxt;
    end
  end

  // result buffer
  assign empty   = (out_cnt_r == '0);
  assign out_pop = pop & ~empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_wr_ptr_r <= '0;
      out_rd_ptr_r <= '0;
      out_cnt_r    <= '0;
    end else begin
      if (emit) begin
        out_wr_ptr_r <= out_wr_ptr_r + 1'b1;
      end
      if (out_pop) begin
        out_rd_ptr_r <= out_rd_ptr_r + 1'b1;
      end
      if (emit && !out_pop) begin
        out_cnt_r <= out_cnt_r + 1'b1;
      end else if (!emit && out_pop) begin
        out_cnt_r <= out_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_mem_r[out_wr_ptr_r] <= res;
    end
  end

  assign sum_real   = out_mem_r[out_rd_ptr_r].sum_re;
  assign sum_imag   = out_mem_r[out_rd_ptr_r].sum_im;
  assign row_number = out_mem_r[out_rd_ptr_r].row;
  assign saturated  = out_mem_r[out_rd_ptr_r].sat;

`ifndef SYNTH
  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result buffer over capacity");

  a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (acc_re_r == '0) && (acc_im_r == '0) && !row_sat_r)
    else $error("row accumulator not cleared after result");

  a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && b2_last_row_r) |=> (row_cnt_r == '0))
    else $error("row numbering not restarted after last row");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && b2_empty_r) |=> (out_mem_r[$past(out_wr_ptr_r)].sum_re == '0) &&
                             (out_mem_r[$past(out_wr_ptr_r)].sum_im == '0) &&
                             !out_mem_r[$past(out_wr_ptr_r)].sat)
    else $error("empty row produced a nonzero result");
`endif

endmodule

[rtl/complex_sparse_matvec.sv]
// Complex sparse matrix times dense vector in compressed row form, Q8.24 in, Q16.48 out.
// Takes one request per cycle while full is low. A load writes the vector store and is
// done; a nonzero or empty-row request reads the store (registered read), waits in a
// four-entry queue, and passes a multiply stage and a term stage before the saturating
// accumulate, which writes each row result into the result buffer on its closing request.
// The 64-bit accumulate carries from one nonzero straight into the next. A nonzero may
// read an entry loaded in the cycle just before it. The result buffer holds two rows;
// while it is full the back end holds and the queue fills, then full rises.
module complex_sparse_matvec
  import csmv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [CMD_W-1:0]        in_command,
  input  logic [ENTRY_W-1:0]      in_entry_index,
  input  logic signed [IN_W-1:0]  in_value_real,
  input  logic signed [IN_W-1:0]  in_value_imag,
  input  logic                    in_last_in_row,
  input  logic                    in_last_row,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [ACC_W-1:0] out_sum_real,
  output logic signed [ACC_W-1:0] out_sum_imag,
  output logic [ROW_W-1:0]        out_row_number,
  output logic                    out_saturated
);

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  work_t q_wr_entry;
  work_t q_rd_entry;

  csmv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .cmd        (in_command),
    .entry_index(in_entry_index),
    .value_real (in_value_real),
    .value_imag (in_value_imag),
    .last_in_row(in_last_in_row),
    .last_row   (in_last_row),
    .q_push     (q_push),
    .q_entry    (q_wr_entry),
    .q_full     (q_full)
  );

  csmv_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_entry(q_wr_entry),
    .full    (q_full),
    .pop     (q_pop),
    .rd_entry(q_rd_entry),
    .valid   (q_valid)
  );

  csmv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_rd_entry),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .sum_real  (out_sum_real),
    .sum_imag  (out_sum_imag),
    .row_number(out_row_number),
    .saturated (out_saturated)
  );

endmodule
